// ----- hw/rtl/kse_pkg.sv -----
// Types, constants and key tables shared by the keypad scanner modules.
`timescale 1ns / 1ps

package kse_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 8'd1;

  localparam logic [7:0]  DEBOUNCE_RESET = 8'd9;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;

  localparam logic [3:0] LAST_KEY = 4'd11;
  localparam logic [2:0] LAST_TAP = 3'd4;

  typedef enum logic [2:0] {
    PH_SCAN0    = 3'd0,
    PH_SCAN1    = 3'd1,
    PH_SCAN2    = 3'd2,
    PH_PRESS_DB = 3'd3,
    PH_WAIT_REL = 3'd4,
    PH_REL_DB   = 3'd5,
    PH_ACT      = 3'd6
  } phase_e;

  typedef struct packed {
    logic [3:0] row_lines;
    logic       tick;
  } in_word_t;

  typedef struct packed {
    logic [2:0] column_drive;
    logic [1:0] char_count;
    logic [7:0] first_char;
    logic [7:0] second_char;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] multitap_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e      scan_phase;
    logic [1:0]  current_column;
    logic [3:0]  detected_key;
    logic        detected_valid;
    logic [3:0]  pending_key;
    logic        pending_valid;
    logic [2:0]  tap_index;
    logic        timeout_armed;
    logic [7:0]  debounce_count;
    logic [15:0] idle_count;
  } state_t;

  localparam logic [7:0] GLYPH_TAB [12][5] = '{
    '{8'h30, 8'h20, 8'h30, 8'h20, 8'h30},
    '{8'h31, 8'h31, 8'h31, 8'h31, 8'h31},
    '{8'h32, 8'h41, 8'h42, 8'h43, 8'h43},
    '{8'h33, 8'h44, 8'h45, 8'h46, 8'h46},
    '{8'h34, 8'h47, 8'h48, 8'h49, 8'h49},
    '{8'h35, 8'h4A, 8'h4B, 8'h4C, 8'h4C},
    '{8'h36, 8'h4D, 8'h4E, 8'h4F, 8'h4F},
    '{8'h37, 8'h50, 8'h51, 8'h52, 8'h53},
    '{8'h38, 8'h54, 8'h55, 8'h56, 8'h56},
    '{8'h39, 8'h57, 8'h58, 8'h59, 8'h5A},
    '{8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A},
    '{8'h23, 8'h23, 8'h23, 8'h23, 8'h23}
  };

  localparam logic [3:0] KEY_TAB [4][3] = '{
    '{4'd1,  4'd2, 4'd3},
    '{4'd4,  4'd5, 4'd6},
    '{4'd7,  4'd8, 4'd9},
    '{4'd10, 4'd0, 4'd11}
  };

  function automatic logic [7:0] glyph(logic [3:0] key, logic [2:0] tap);
    logic [2:0] t;
    t = (tap > LAST_TAP) ? LAST_TAP : tap;
    if (key > LAST_KEY) begin
      return 8'h00;
    end
    return GLYPH_TAB[key][t];
  endfunction

  function automatic logic [2:0] letter_count(logic [3:0] key);
    logic [2:0] m;
    case (key)
      4'd0:       m = 3'd2;
      4'd1:       m = 3'd1;
      4'd7, 4'd9: m = 3'd5;
      4'd10:      m = 3'd1;
      4'd11:      m = 3'd1;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: m = 3'd4;
      default:    m = 3'd1;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] tap_advance(logic [2:0] tap, logic [2:0] m);
    logic [3:0] t;
    logic [3:0] r;
    t = {1'b0, tap} + 4'd1;
    case (m)
      3'd2:    r = {3'b000, t[0]};
      3'd4:    r = {2'b00, t[1:0]};
      3'd5:    r = (t >= 4'd5) ? (t - 4'd5) : t;
      default: r = 4'd0;
    endcase
    return r[2:0];
  endfunction

endpackage

// ----- hw/rtl/keypad_scan_multitap_entry.sv -----
// Top level of the 3 by 4 keypad scanner with multi-tap text entry.
//
//   channel | direction | handshake                 | word
//   in      | in        | in_valid_i / in_ready_o   | in_data_i   (row_lines, tick)
//   out     | out       | out_valid_o / out_ready_i | out_data_o  (column, chars)
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The path runs through the input register, one step of next-state logic and the result register.
// One word per cycle is sustained while the result is taken; the step logic is a single combinational pass.
// Reset clears the scan state and loads debounce 9 and timeout 500 ticks.
// A stalled result holds the step; the input register keeps one word while it waits.
`timescale 1ns / 1ps

module keypad_scan_multitap_entry (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  kse_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output kse_pkg::out_word_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kse_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kse_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  kse_pkg::cfg_t      cfg;
  kse_pkg::in_word_t  in_word_q;
  logic               in_vld_q;
  kse_pkg::out_word_t out_word_q;
  kse_pkg::out_word_t out_word_d;
  logic               out_vld_q;
  kse_pkg::state_t    state_q;
  kse_pkg::state_t    state_d;
  logic               advance;

  kse_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kse_step u_step (
    .state_i (state_q),
    .word_i  (in_word_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .word_o  (out_word_d)
  );

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{scan_phase: kse_pkg::PH_SCAN0, default: '0};
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_word_q <= in_data_i;
    if (advance) out_word_q <= out_word_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_word_q;

endmodule

// ----- hw/rtl/kse_cfg.sv -----
// Configuration registers for debounce length and multi-tap timeout.
`timescale 1ns / 1ps

module kse_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [kse_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kse_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output kse_pkg::cfg_t                   cfg_o
);

  kse_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks         <= kse_pkg::DEBOUNCE_RESET;
      cfg_q.multitap_timeout_ticks <= kse_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == kse_pkg::REG_DEBOUNCE_TICKS) begin
        cfg_q.debounce_ticks <= cfg_data_i[7:0];
      end
      if (cfg_index_i == kse_pkg::REG_TIMEOUT_TICKS) begin
        cfg_q.multitap_timeout_ticks <= cfg_data_i[15:0];
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/kse_step.sv -----
// Next-state and result logic for one scan step.
`timescale 1ns / 1ps

module kse_step (
  input  kse_pkg::state_t    state_i,
  input  kse_pkg::in_word_t  word_i,
  input  kse_pkg::cfg_t      cfg_i,
  output kse_pkg::state_t    state_o,
  output kse_pkg::out_word_t word_o
);

  kse_pkg::state_t s;
  logic [1:0]      n;
  logic [7:0]      c0;
  logic [7:0]      c1;
  logic [7:0]      g;
  logic [1:0]      row;
  logic            start;

  always_comb begin
    s     = state_i;
    n     = 2'd0;
    c0    = 8'h00;
    c1    = 8'h00;
    g     = 8'h00;
    row   = 2'd3;
    start = 1'b0;

    if (word_i.tick) begin
      if (s.debounce_count != 8'hFF) s.debounce_count = s.debounce_count + 8'd1;
      if (s.idle_count != 16'hFFFF) s.idle_count = s.idle_count + 16'd1;
    end

    case (s.scan_phase)
      kse_pkg::PH_SCAN0, kse_pkg::PH_SCAN1, kse_pkg::PH_SCAN2: begin
        if (s.timeout_armed && (s.idle_count >= cfg_i.multitap_timeout_ticks)) begin
          if (s.pending_valid) begin
            c0 = kse_pkg::glyph(s.pending_key, s.tap_index);
            n  = 2'd1;
          end
          s.pending_valid  = 1'b0;
          s.pending_key    = 4'd0;
          s.tap_index      = 3'd0;
          s.timeout_armed  = 1'b0;
          s.scan_phase     = kse_pkg::PH_SCAN0;
          s.current_column = 2'd0;
        end else if (word_i.row_lines != 4'hF) begin
          s.debounce_count = 8'd0;
          s.scan_phase     = kse_pkg::PH_PRESS_DB;
        end else begin
          case (s.scan_phase)
            kse_pkg::PH_SCAN0: begin
              s.scan_phase     = kse_pkg::PH_SCAN1;
              s.current_column = 2'd1;
            end
            kse_pkg::PH_SCAN1: begin
              s.scan_phase     = kse_pkg::PH_SCAN2;
              s.current_column = 2'd2;
            end
            default: begin
              s.scan_phase     = kse_pkg::PH_SCAN0;
              s.current_column = 2'd0;
            end
          endcase
        end
      end
      kse_pkg::PH_PRESS_DB: begin
        if (s.debounce_count >= cfg_i.debounce_ticks) begin
          if (!word_i.row_lines[0])      row = 2'd0;
          else if (!word_i.row_lines[1]) row = 2'd1;
          else if (!word_i.row_lines[2]) row = 2'd2;
          else                           row = 2'd3;
          if ((word_i.row_lines != 4'hF) && (s.current_column != 2'd3)) begin
            s.detected_key   = kse_pkg::KEY_TAB[row][s.current_column];
            s.detected_valid = 1'b1;
          end else begin
            s.detected_key   = 4'd0;
            s.detected_valid = 1'b0;
          end
          s.scan_phase = kse_pkg::PH_WAIT_REL;
        end
      end
      kse_pkg::PH_WAIT_REL: begin
        if (word_i.row_lines == 4'hF) begin
          s.debounce_count = 8'd0;
          s.scan_phase     = kse_pkg::PH_REL_DB;
        end
      end
      kse_pkg::PH_REL_DB: begin
        if (s.debounce_count >= cfg_i.debounce_ticks) s.scan_phase = kse_pkg::PH_ACT;
      end
      kse_pkg::PH_ACT: begin
        if (s.detected_valid) begin
          if (s.pending_valid && (s.pending_key != s.detected_key)) begin
            c0    = kse_pkg::glyph(s.pending_key, s.tap_index);
            n     = 2'd1;
            start = 1'b1;
          end else if (!s.pending_valid) begin
            start = 1'b1;
          end else if (kse_pkg::letter_count(s.pending_key) > 3'd1) begin
            s.tap_index     = kse_pkg::tap_advance(s.tap_index,
                                                   kse_pkg::letter_count(s.pending_key));
            s.idle_count    = 16'd0;
            s.timeout_armed = 1'b1;
          end else begin
            c0              = kse_pkg::glyph(s.pending_key, 3'd0);
            n               = 2'd1;
            s.pending_valid = 1'b0;
            s.pending_key   = 4'd0;
            s.tap_index     = 3'd0;
            s.timeout_armed = 1'b0;
          end
          if (start) begin
            s.pending_key   = s.detected_key;
            s.pending_valid = 1'b1;
            s.tap_index     = 3'd0;
            s.idle_count    = 16'd0;
            s.timeout_armed = 1'b1;
            if (kse_pkg::letter_count(s.detected_key) == 3'd1) begin
              g = kse_pkg::glyph(s.detected_key, 3'd0);
              if (n == 2'd0) c0 = g;
              else           c1 = g;
              n               = n + 2'd1;
              s.pending_valid = 1'b0;
              s.pending_key   = 4'd0;
              s.tap_index     = 3'd0;
              s.timeout_armed = 1'b0;
            end
          end
        end
        s.scan_phase     = kse_pkg::PH_SCAN0;
        s.current_column = 2'd0;
      end
      default: begin
        s.scan_phase     = kse_pkg::PH_SCAN0;
        s.current_column = 2'd0;
      end
    endcase

    case (s.current_column)
      2'd0:    word_o.column_drive = 3'b110;
      2'd1:    word_o.column_drive = 3'b101;
      2'd2:    word_o.column_drive = 3'b011;
      default: word_o.column_drive = 3'b111;
    endcase
    word_o.char_count  = n;
    word_o.first_char  = c0;
    word_o.second_char = c1;
    state_o            = s;
  end

endmodule

// ----- hw/rtl/kse_checker.sv -----
// Port checker for the keypad scanner and its bind to the top level.
`timescale 1ns / 1ps

module kse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kse_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word dropped or changed while stalled");

  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(~out_data_o.column_drive) <= 1))
    else $error("more than one column driven");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.char_count != 2'd3))
    else $error("character count out of range");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.char_count != 2'd2)) |->
      ((out_data_o.second_char == 8'h00) &&
       ((out_data_o.char_count != 2'd0) || (out_data_o.first_char == 8'h00))))
    else $error("unsent character slot not zero");

endmodule

bind keypad_scan_multitap_entry kse_checker u_kse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/keypad_scan_multitap_entry_test.sv -----
// Self-checking testbench for the keypad scanner with multi-tap text entry.
`timescale 1ns / 1ps

module keypad_scan_multitap_entry_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct {
    logic [11:0] held;
    logic [3:0]  stray_rows;
    logic        tick;
    logic        drain_first;
  } pad_sample_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  kse_pkg::in_word_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  kse_pkg::out_word_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [kse_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kse_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pad_sample_t        pending_samples[$];
  kse_pkg::out_word_t expected_words[$];
  pad_sample_t        next_sample;
  kse_pkg::out_word_t step_result;
  kse_pkg::out_word_t want;
  logic               drain_next = 1'b0;
  int                 queued_words = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  // scanner state as predicted
  kse_pkg::phase_e scan_ph = kse_pkg::PH_SCAN0;
  logic [1:0]      scan_col = '0;
  logic [3:0]      found_key = '0;
  logic            found_ok = 1'b0;
  logic [3:0]      entry_key = '0;
  logic            entry_ok = 1'b0;
  logic [2:0]      entry_tap = '0;
  logic            entry_armed = 1'b0;
  logic [7:0]      bounce_ticks = '0;
  logic [15:0]     idle_ticks = '0;
  logic [7:0]      debounce_limit = 8'd9;
  logic [15:0]     timeout_limit = 16'd500;
  logic [1:0]      sent_n;
  logic [7:0]      sent_first;
  logic [7:0]      sent_second;

  keypad_scan_multitap_entry u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] char_of(logic [3:0] key, logic [2:0] tap);
    logic [39:0] glyphs;
    int t;
    t = (tap > 3'd4) ? 4 : int'(tap);
    case (key)
      4'd0:    glyphs = "0 0 0";
      4'd1:    glyphs = "11111";
      4'd2:    glyphs = "2ABCC";
      4'd3:    glyphs = "3DEFF";
      4'd4:    glyphs = "4GHII";
      4'd5:    glyphs = "5JKLL";
      4'd6:    glyphs = "6MNOO";
      4'd7:    glyphs = "7PQRS";
      4'd8:    glyphs = "8TUVV";
      4'd9:    glyphs = "9WXYZ";
      4'd10:   glyphs = "*****";
      4'd11:   glyphs = "#####";
      default: glyphs = '0;
    endcase
    return glyphs[8*(4-t) +: 8];
  endfunction

  function automatic logic [2:0] taps_for(logic [3:0] key);
    case (key)
      4'd0:                               return 3'd2;
      4'd7, 4'd9:                         return 3'd5;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: return 3'd4;
      default:                            return 3'd1;
    endcase
  endfunction

  function automatic logic [3:0] key_at(logic [1:0] r, logic [1:0] c);
    if (r == 2'd3) begin
      return (c == 2'd0) ? 4'd10 : (c == 2'd1) ? 4'd0 : 4'd11;
    end
    return 4'(r * 3 + c + 1);
  endfunction

  function automatic logic [3:0] rows_under(logic [11:0] held, logic [3:0] stray,
                                            logic [1:0] c);
    logic [3:0] r;
    r = ~stray;
    for (int k = 0; k < 4; k++) begin
      if (c < 2'd3 && held[k*3 + c]) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic tick_bit(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic put_char(logic [7:0] c);
    if (sent_n == 2'd0) begin
      sent_first = c;
    end else if (sent_n == 2'd1) begin
      sent_second = c;
    end
    if (sent_n < 2'd2) begin
      sent_n = sent_n + 2'd1;
    end
  endtask

  task automatic clear_entry();
    entry_ok = 1'b0;
    entry_key = '0;
    entry_tap = '0;
    entry_armed = 1'b0;
  endtask

  task automatic open_entry(logic [3:0] key);
    entry_key = key;
    entry_ok = 1'b1;
    entry_tap = '0;
    idle_ticks = '0;
    entry_armed = 1'b1;
    if (taps_for(key) == 3'd1) begin
      put_char(char_of(key, 3'd0));
      clear_entry();
    end
  endtask

  task automatic act_on_found();
    logic [2:0] m;
    logic [3:0] nxt;
    if (!found_ok) begin
      return;
    end
    if (entry_ok && entry_key != found_key) begin
      put_char(char_of(entry_key, entry_tap));
      open_entry(found_key);
    end else if (!entry_ok) begin
      open_entry(found_key);
    end else begin
      m = taps_for(entry_key);
      if (m > 3'd1) begin
        nxt = {1'b0, entry_tap} + 4'd1;
        entry_tap = 3'(nxt % {1'b0, m});
        idle_ticks = '0;
        entry_armed = 1'b1;
      end else begin
        put_char(char_of(entry_key, 3'd0));
        clear_entry();
      end
    end
  endtask

  task automatic scan_step(kse_pkg::in_word_t w, output kse_pkg::out_word_t r);
    logic [1:0] row;
    sent_n = '0;
    sent_first = '0;
    sent_second = '0;
    if (w.tick) begin
      if (bounce_ticks != 8'hFF) bounce_ticks = bounce_ticks + 8'd1;
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
    end
    case (scan_ph)
      kse_pkg::PH_SCAN0, kse_pkg::PH_SCAN1, kse_pkg::PH_SCAN2: begin
        if (entry_armed && idle_ticks >= timeout_limit) begin
          if (entry_ok) put_char(char_of(entry_key, entry_tap));
          clear_entry();
          scan_ph = kse_pkg::PH_SCAN0;
          scan_col = '0;
        end else if (w.row_lines != 4'hF) begin
          bounce_ticks = '0;
          scan_ph = kse_pkg::PH_PRESS_DB;
        end else begin
          scan_ph = (scan_ph == kse_pkg::PH_SCAN2) ? kse_pkg::PH_SCAN0 :
                    kse_pkg::phase_e'(scan_ph + 3'd1);
          scan_col = 2'(scan_ph);
        end
      end
      kse_pkg::PH_PRESS_DB: begin
        if (bounce_ticks >= debounce_limit) begin
          row = !w.row_lines[0] ? 2'd0 : !w.row_lines[1] ? 2'd1 :
                !w.row_lines[2] ? 2'd2 : 2'd3;
          if (w.row_lines != 4'hF && scan_col < 2'd3) begin
            found_key = key_at(row, scan_col);
            found_ok = 1'b1;
          end else begin
            found_key = '0;
            found_ok = 1'b0;
          end
          scan_ph = kse_pkg::PH_WAIT_REL;
        end
      end
      kse_pkg::PH_WAIT_REL: begin
        if (w.row_lines == 4'hF) begin
          bounce_ticks = '0;
          scan_ph = kse_pkg::PH_REL_DB;
        end
      end
      kse_pkg::PH_REL_DB: begin
        if (bounce_ticks >= debounce_limit) scan_ph = kse_pkg::PH_ACT;
      end
      kse_pkg::PH_ACT: begin
        act_on_found();
        scan_ph = kse_pkg::PH_SCAN0;
        scan_col = '0;
      end
      default: begin
        scan_ph = kse_pkg::PH_SCAN0;
        scan_col = '0;
      end
    endcase
    r.column_drive = (scan_col < 2'd3) ? ~(3'b001 << scan_col) : 3'b111;
    r.char_count = sent_n;
    r.first_char = sent_first;
    r.second_char = sent_second;
  endtask

  task automatic check_field(string what, logic [7:0] exp_val, logic [7:0] got);
    if (exp_val !== got) begin
      $display("%0t ns: %s expected %h got %h", $time, what, exp_val, got);
      mismatches++;
    end
  endtask

  task automatic queue_word(logic [11:0] held, logic [3:0] stray, logic tick);
    pending_samples.push_back('{held, stray, tick, drain_next});
    drain_next = 1'b0;
    queued_words++;
  endtask

  task automatic queue_hold(logic [11:0] held, int ticks_needed, int pct);
    int got;
    logic t;
    got = 0;
    do begin
      t = tick_bit(pct);
      queue_word(held, 4'h0, t);
      got += int'(t);
    end while (got < ticks_needed);
  endtask

  task automatic queue_press(int pos, int alt, int pct, bit partial);
    logic [11:0] held;
    held = 12'b1 << pos;
    if (alt >= 0) held[alt] = 1'b1;
    if (partial) begin
      repeat ($urandom_range(1, 3)) queue_word(held, 4'h0, tick_bit(pct));
    end else begin
      repeat (4) queue_word(held, 4'h0, tick_bit(pct));
      queue_hold(held, int'(debounce_limit), pct);
      repeat ($urandom_range(0, 1)) queue_word(held, 4'h0, tick_bit(pct));
      queue_word(12'h0, 4'h0, tick_bit(pct));
      queue_hold(12'h0, int'(debounce_limit), pct);
      queue_word(12'h0, 4'h0, tick_bit(pct));
    end
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [kse_pkg::CFG_IDX_W-1:0] idx,
                           logic [kse_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == kse_pkg::REG_DEBOUNCE_TICKS) begin
      debounce_limit = value[7:0];
    end else if (idx == kse_pkg::REG_TIMEOUT_TICKS) begin
      timeout_limit = value;
    end
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [7:0] db, logic [15:0] idle_limit, int send_pct,
                           int recv_pct, int pct, int target);
    int start;
    int alt;
    settle();
    write_reg(kse_pkg::REG_DEBOUNCE_TICKS, {8'($urandom), db});
    write_reg(kse_pkg::REG_TIMEOUT_TICKS, idle_limit);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = queued_words;
    while (queued_words - start < target) begin
      if ($urandom_range(19) == 0) drain_next = 1'b1;
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 4)) queue_word(12'($urandom), 4'($urandom), tick_bit(pct));
        end
        1: begin
          queue_press($urandom_range(11), -1, pct, 1'b1);
        end
        default: begin
          alt = ($urandom_range(6) == 0) ? int'($urandom_range(11)) : -1;
          queue_press($urandom_range(11), alt, pct, 1'b0);
        end
      endcase
      if (timeout_limit <= 16'd100 && $urandom_range(3) == 0) begin
        queue_hold(12'h0, int'(timeout_limit) + 2, pct);
      end else begin
        repeat ($urandom_range(0, 3)) queue_word(12'h0, 4'h0, tick_bit(pct));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_step(in_data, step_result);
        expected_words.push_back(step_result);
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_samples[0].drain_first && expected_words.size() != 0)) begin
          next_sample = pending_samples.pop_front();
          in_data <= {rows_under(next_sample.held, next_sample.stray_rows, scan_col),
                      next_sample.tick};
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t ns: word %h with nothing expected", $time, out_data);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("column_drive", 8'(want.column_drive), 8'(out_data.column_drive));
          check_field("char_count", 8'(want.char_count), 8'(out_data.char_count));
          check_field("first_char", want.first_char, out_data.first_char);
          check_field("second_char", want.second_char, out_data.second_char);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(kse_pkg::REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(kse_pkg::REG_TIMEOUT_TICKS, 16'd12);
    queue_press(6, -1, 100, 1'b0);
    queue_press(6, -1, 100, 1'b0);
    queue_press(0, -1, 100, 1'b0);
    queue_press(1, 4, 100, 1'b0);
    queue_press(10, -1, 100, 1'b0);
    drain_next = 1'b1;
    queue_hold(12'h0, 14, 100);
    // drop the press before it is decoded
    queue_word(12'h0, 4'b0001, 1'b1);
    queue_hold(12'h0, 2, 100);
    queue_press(11, -1, 100, 1'b0);

    run_phase(8'd1, 16'd40, 0, 0, 80, 120);
    run_phase(8'd0, 16'd0, 85, 0, 70, 120);
    run_phase(8'd3, 16'hFFFF, 0, 85, 90, 120);
    run_phase(8'd2, 16'd15, 26, 26, 75, 120);
    run_phase(8'd255, 16'd300, 0, 0, 100, 300);
    run_phase(8'd9, 16'd500, 26, 26, 60, 120);
    settle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
